FILE: rtl/pee_pkg.sv
// Package: shared types and constants of the prefix expression evaluator.
`timescale 1ns / 1ps
package pee_pkg;

  localparam int MAX_CHARS = 64;
  localparam int ADDR_W    = $clog2(MAX_CHARS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int VALUE_W   = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_POW   = 8'h5e;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADCOUNT = 3'd1;
  localparam logic [2:0] ST_UNDER    = 3'd2;
  localparam logic [2:0] ST_DIVZERO  = 3'd3;
  localparam logic [2:0] ST_TOOLONG  = 3'd4;
  localparam logic [2:0] ST_ZERONEG  = 3'd5;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [2:0]       status;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

endpackage

FILE: rtl/pee_front.sv
// Front end: loads characters, keeps count and balance, issues evaluation jobs.
`timescale 1ns / 1ps
module pee_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pee_pkg::in_req_t  in_req,
  input  logic              q_full,
  output logic              q_push,
  output pee_pkg::job_t     q_job,
  input  logic              release_buf,
  output pee_pkg::buf_wr_t buf_wr
);

  logic [pee_pkg::CNT_W-1:0] count_r;
  logic signed [7:0]         bal_r;
  logic                      ovl_r;
  logic                      busy_r;
  logic                      acc;
  logic                      full;
  logic                      is_digit;
  logic signed [7:0]         bal_nxt;
  logic                      ovl_nxt;

  assign in_stall = busy_r | q_full;
  assign acc      = in_valid & ~in_stall;
  assign full     = (count_r == pee_pkg::CNT_W'(pee_pkg::MAX_CHARS));
  assign is_digit = (in_req.char_code >= pee_pkg::CH_ZERO) &&
                    (in_req.char_code <= pee_pkg::CH_NINE);
  assign bal_nxt  = is_digit ? bal_r + 8'sd1 : bal_r - 8'sd1;
  assign ovl_nxt  = ovl_r | full;

  assign buf_wr.we   = acc & ~full;
  assign buf_wr.addr = count_r[pee_pkg::ADDR_W-1:0];
  assign buf_wr.data = in_req.char_code;

  assign q_push     = acc & in_req.last_char;
  assign q_job.len  = full ? count_r : count_r + 1'b1;
  assign q_job.status = ovl_nxt ? pee_pkg::ST_TOOLONG :
                        (bal_nxt != 8'sd1) ? pee_pkg::ST_BADCOUNT : pee_pkg::ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bal_r   <= '0;
      ovl_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      if (release_buf) busy_r <= 1'b0;
      if (acc) begin
        if (in_req.last_char) begin
          count_r <= '0;
          bal_r   <= '0;
          ovl_r   <= 1'b0;
          busy_r  <= 1'b1;
        end else begin
          if (!full) count_r <= count_r + 1'b1;
          bal_r <= bal_nxt;
          ovl_r <= ovl_nxt;
        end
      end
    end
  end

endmodule

FILE: rtl/pee_queue.sv
// Two-entry job queue between front end and evaluator.
`timescale 1ns / 1ps
module pee_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pee_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output pee_pkg::job_t head
);

  pee_pkg::job_t ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) ent_r[wp_r] <= push_job;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && not_empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end
  end

endmodule

FILE: rtl/pee_back.sv
// Evaluator: reverse scan of the buffer on a value stack, iterative divide and power.
`timescale 1ns / 1ps
module pee_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pee_pkg::buf_wr_t buf_wr,
  input  logic              q_not_empty,
  input  pee_pkg::job_t     q_head,
  output logic              q_pop,
  output logic              release_buf,
  output logic              out_valid,
  input  logic              out_stall,
  output pee_pkg::out_req_t out_req
);

  localparam int AW = pee_pkg::ADDR_W;
  localparam int CW = pee_pkg::CNT_W;
  localparam int VW = pee_pkg::VALUE_W;
  localparam int DW = $clog2(VW);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FETCH = 8'b00000010,
    S_EXEC  = 8'b00000100,
    S_MUL   = 8'b00001000,
    S_DIV   = 8'b00010000,
    S_PWRR  = 8'b00100000,
    S_PWRB  = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  state_t           state_r;
  logic [7:0]       buf_mem [pee_pkg::MAX_CHARS];
  logic [VW-1:0]    stk_mem [pee_pkg::MAX_CHARS];
  logic [7:0]       buf_q;
  logic [VW-1:0]    nos_q;
  logic [CW-1:0]    idx_r, sp_r;
  logic [VW-1:0]    tos_r, opx_r, opy_r, acc_r, quo_r;
  logic [VW-1:0]    rem_r;
  logic [DW-1:0]    dcnt_r;
  logic             negq_r;
  logic [2:0]       stat_r;
  logic             out_valid_r;
  pee_pkg::out_req_t out_r;

  logic [AW-1:0]    rd_addr, stk_raddr, stk_waddr;
  logic             stk_we;
  logic [VW-1:0]    y, x, cval, mul_a, mul_b, prod;
  logic [VW:0]      rem_sh, diff;
  logic             is_op, out_free;

  assign rd_addr   = idx_r[AW-1:0] - 1'b1;
  assign stk_raddr = sp_r[AW-1:0] - AW'(2);
  assign stk_waddr = sp_r[AW-1:0] - 1'b1;
  assign y    = tos_r;
  assign x    = nos_q;
  assign cval = {{(VW-8){1'b0}}, buf_q} - VW'(48);
  assign is_op = (buf_q == pee_pkg::CH_PLUS) || (buf_q == pee_pkg::CH_MINUS) ||
                 (buf_q == pee_pkg::CH_MUL)  || (buf_q == pee_pkg::CH_DIV) ||
                 (buf_q == pee_pkg::CH_POW);
  assign stk_we = (state_r == S_EXEC) && !is_op && (sp_r != '0);

  // one shared multiplier, low half only
  always_comb begin
    mul_a = opx_r;
    mul_b = opy_r;
    if (state_r == S_PWRR) mul_a = acc_r;
    if (state_r == S_PWRB) mul_a = opy_r;
  end
  assign prod = VW'(mul_a * mul_b);

  assign rem_sh = {rem_r, quo_r[VW-1]};
  assign diff   = rem_sh - {1'b0, opx_r};

  assign out_free    = !out_valid_r || !out_stall;
  assign q_pop       = (state_r == S_IDLE) && q_not_empty;
  assign release_buf = (state_r == S_FIN) && out_free;
  assign out_valid   = out_valid_r;
  assign out_req     = out_r;

  always_ff @(posedge clk) begin
    if (buf_wr.we) buf_mem[buf_wr.addr] <= buf_wr.data;
    buf_q <= buf_mem[rd_addr];
    if (stk_we) stk_mem[stk_waddr] <= tos_r;
    nos_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      sp_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            stat_r <= q_head.status;
            idx_r  <= q_head.len;
            sp_r   <= '0;
            state_r <= (q_head.status == pee_pkg::ST_OK) ? S_FETCH : S_FIN;
          end
        end
        S_FETCH: begin
          if (idx_r == '0) begin
            stat_r  <= (sp_r == '0) ? pee_pkg::ST_UNDER : pee_pkg::ST_OK;
            state_r <= S_FIN;
          end else begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          idx_r   <= idx_r - 1'b1;
          state_r <= S_FETCH;
          if (!is_op) begin
            tos_r <= cval;
            sp_r  <= sp_r + 1'b1;
          end else if (sp_r < CW'(2)) begin
            stat_r  <= pee_pkg::ST_UNDER;
            state_r <= S_FIN;
          end else begin
            sp_r <= sp_r - 1'b1;
            case (buf_q)
              pee_pkg::CH_PLUS:  tos_r <= y + x;
              pee_pkg::CH_MINUS: tos_r <= y - x;
              pee_pkg::CH_MUL: begin
                opx_r   <= x;
                opy_r   <= y;
                state_r <= S_MUL;
              end
              pee_pkg::CH_DIV: begin
                if (x == '0) begin
                  stat_r  <= pee_pkg::ST_DIVZERO;
                  state_r <= S_FIN;
                end else begin
                  negq_r  <= x[VW-1] ^ y[VW-1];
                  opx_r   <= x[VW-1] ? -x : x;
                  quo_r   <= y[VW-1] ? -y : y;
                  rem_r   <= '0;
                  dcnt_r  <= '0;
                  state_r <= S_DIV;
                end
              end
              default: begin
                if (x[VW-1]) begin
                  if (y == '0) begin
                    stat_r  <= pee_pkg::ST_ZERONEG;
                    state_r <= S_FIN;
                  end else if (y == VW'(1)) begin
                    tos_r <= VW'(1);
                  end else if (&y) begin
                    tos_r <= x[0] ? '1 : VW'(1);
                  end else begin
                    tos_r <= '0;
                  end
                end else begin
                  acc_r   <= VW'(1);
                  opy_r   <= y;
                  opx_r   <= x;
                  state_r <= S_PWRR;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          tos_r   <= prod;
          state_r <= S_FETCH;
        end
        S_DIV: begin
          if (!diff[VW]) begin
            rem_r <= diff[VW-1:0];
            quo_r <= {quo_r[VW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[VW-1:0];
            quo_r <= {quo_r[VW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (&dcnt_r) begin
            tos_r   <= negq_r ? -{quo_r[VW-2:0], !diff[VW]} : {quo_r[VW-2:0], !diff[VW]};
            state_r <= S_FETCH;
          end
        end
        S_PWRR: begin
          if (opx_r == '0) begin
            tos_r   <= acc_r;
            state_r <= S_FETCH;
          end else begin
            if (opx_r[0]) acc_r <= prod;
            state_r <= S_PWRB;
          end
        end
        S_PWRB: begin
          opy_r   <= prod;
          opx_r   <= opx_r >> 1;
          state_r <= S_PWRR;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_r.status <= stat_r;
            out_r.value  <= (stat_r == pee_pkg::ST_OK) ? tos_r : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(pee_pkg::MAX_CHARS))
    else $error("value stack pointer past depth");
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> opx_r != '0)
    else $error("divide started with zero divisor");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != pee_pkg::ST_OK |-> out_r.value == '0)
    else $error("nonzero value with error status");
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    release_buf |=> out_valid_r)
    else $error("buffer released without result");
`endif

endmodule

FILE: rtl/prefix_expression_evaluator_core.sv
// Top level: prefix expression evaluator core.
`timescale 1ns / 1ps
// Prefix expression evaluator.
// Input channel (in_valid / in_stall / in_req): one ASCII character per
// request, in text order; in_req.last_char marks the end of an expression.
// Characters load at one per cycle, unless input is stalled, into a 64-entry
// buffer; the front end keeps a digit-minus-other balance and overlength flag.
// On the last character the front end queues a job and stalls further input
// until the evaluator has finished with the buffer.
// Output channel (out_valid / out_stall / out_req): one request per
// expression with the 32-bit value and a status code (nonzero = error, value 0).
// After the last character the evaluator scans the buffer backwards, pushing
// a value per non-operator character and applying each operator; / works out
// one quotient bit per cycle and ^ squares and multiplies per exponent bit
// (one shared 32x32 multiplier; a negative exponent needs no loop).
// Failed pre-checks (too long, bad count) go straight to the finish step.
// A stalled result holds in the output register; the evaluator then waits in
// its finish step and input stays stalled until the result is taken.
// Reset (rst_n low, synchronous) empties the queue, clears count, balance and
// output valid; buffer and stack contents are left as they are.
module prefix_expression_evaluator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pee_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output pee_pkg::out_req_t out_req
);

  logic             q_full, q_push, q_pop, q_not_empty, release_buf;
  pee_pkg::job_t    q_job, q_head;
  pee_pkg::buf_wr_t buf_wr;

  pee_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req,
    .q_full, .q_push, .q_job, .release_buf, .buf_wr
  );

  pee_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_job(q_job), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .head(q_head)
  );

  pee_back u_back (
    .clk, .rst_n, .buf_wr, .q_not_empty, .q_head, .q_pop, .release_buf,
    .out_valid, .out_stall, .out_req
  );

endmodule

FILE: tb/tb_prefix_expression_evaluator_core.sv
// Testbench for the prefix expression evaluator core: random expressions, scoreboard check.
`timescale 1ns / 1ps

// Predicts each result from the characters taken and checks the block's answers in order.
class expr_scoreboard;
  logic [7:0]      chars[$];
  int              balance;
  bit              overlong;
  pee_pkg::out_req_t pending[$];
  int              errors;

  function new();
    balance = 0;
    overlong = 0;
    errors = 0;
  endfunction

  // Work out the value and status of the buffered expression.
  function pee_pkg::out_req_t evaluate();
    pee_pkg::out_req_t r;
    logic [31:0] stk[$];
    logic [31:0] y, x, z, b, acc, my, mx, q;
    logic [7:0] c;
    r.value = '0;
    r.status = pee_pkg::ST_OK;
    for (int i = chars.size() - 1; i >= 0; i--) begin
      c = chars[i];
      if (c != pee_pkg::CH_PLUS && c != pee_pkg::CH_MINUS && c != pee_pkg::CH_MUL &&
          c != pee_pkg::CH_DIV && c != pee_pkg::CH_POW) begin
        stk.push_back({24'd0, c} - 32'd48);
        continue;
      end
      if (stk.size() < 2) begin
        r.status = pee_pkg::ST_UNDER;
        return r;
      end
      y = stk.pop_back();
      x = stk.pop_back();
      case (c)
        pee_pkg::CH_PLUS:  z = y + x;
        pee_pkg::CH_MINUS: z = y - x;
        pee_pkg::CH_MUL:   z = x * y;
        pee_pkg::CH_DIV: begin
          if (x == 0) begin
            r.status = pee_pkg::ST_DIVZERO;
            return r;
          end
          my = y[31] ? -y : y;
          mx = x[31] ? -x : x;
          q = my / mx;
          z = (y[31] != x[31]) ? -q : q;
        end
        default: begin
          if (x[31]) begin
            if (y == 0) begin
              r.status = pee_pkg::ST_ZERONEG;
              return r;
            end
            if (y == 1) z = 1;
            else if (y == 32'hffffffff) z = x[0] ? 32'hffffffff : 32'd1;
            else z = 0;
          end else begin
            acc = 1;
            b = y;
            for (int k = 0; k < 32; k++) begin
              if (x[k]) acc = acc * b;
              b = b * b;
            end
            z = acc;
          end
        end
      endcase
      stk.push_back(z);
    end
    if (stk.size() == 0) r.status = pee_pkg::ST_UNDER;
    else r.value = stk[stk.size() - 1];
    return r;
  endfunction

  function void note_char(pee_pkg::in_req_t req);
    pee_pkg::out_req_t r;
    if (chars.size() < pee_pkg::MAX_CHARS) chars.push_back(req.char_code);
    else overlong = 1;
    if (req.char_code >= pee_pkg::CH_ZERO && req.char_code <= pee_pkg::CH_NINE) balance++;
    else balance--;
    if (!req.last_char) return;
    r.value = '0;
    if (overlong) r.status = pee_pkg::ST_TOOLONG;
    else if (balance != 1) r.status = pee_pkg::ST_BADCOUNT;
    else r = evaluate();
    if (r.status != pee_pkg::ST_OK) r.value = '0;
    pending.push_back(r);
    chars.delete();
    balance = 0;
    overlong = 0;
  endfunction

  function void check_result(pee_pkg::out_req_t got);
    pee_pkg::out_req_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result value=%0d status=%0d", $time, got.value, got.status);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.value !== exp_r.value) begin
      $display("%0t: value expected %0d actual %0d", $time, exp_r.value, got.value);
      errors++;
    end
    if (got.status !== exp_r.status) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
      errors++;
    end
  endfunction
endclass

module tb_prefix_expression_evaluator_core;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  pee_pkg::in_req_t  in_req;
  logic              out_valid;
  logic              out_stall;
  pee_pkg::out_req_t out_req;

  expr_scoreboard sb;
  int       send_idle_pct;   // chance of a gap before each request
  int       stall_pct;       // chance the result side stalls in a cycle

  prefix_expression_evaluator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_req(out_req)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(in_req);
      if (out_valid && !out_stall) sb.check_result(out_req);
    end
  end

  // Result-side back pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Present one request and hold it until taken; gaps are random.
  task automatic send_char(input logic [7:0] c, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req.char_code <= c;
    in_req.last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    in_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_digit();
    return pee_pkg::CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(4))
      0: return pee_pkg::CH_PLUS;
      1: return pee_pkg::CH_MINUS;
      2: return pee_pkg::CH_MUL;
      3: return pee_pkg::CH_DIV;
      default: return pee_pkg::CH_POW;
    endcase
  endfunction

  // Builds a well formed prefix expression with n operators.
  function automatic string rand_prefix(input int n);
    string s;
    logic [7:0] c;
    if (n == 0) begin
      c = rand_digit();
      s = string'(c);
      return s;
    end
    begin
      int lhs;
      lhs = $urandom_range(n - 1);
      c = rand_op();
      s = {string'(c), rand_prefix(lhs), rand_prefix(n - 1 - lhs)};
    end
    return s;
  endfunction

  // Random string of exactly n characters of any nonzero byte code.
  function automatic string rand_noise(input int n);
    string s;
    logic [7:0] c;
    s = "";
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(255));
      if (c == 0) c = 8'd1;  // strings cannot hold nul; sent separately
      s = {s, string'(c)};
    end
    return s;
  endfunction

  // Mutate one character of a string to a random byte.
  function automatic string corrupt(input string s);
    int p;
    p = $urandom_range(s.len() - 1);
    s[p] = 8'($urandom_range(1, 255));
    return s;
  endfunction

  task automatic run_phase(input int n_items, input int idle, input int stall);
    int items;
    int kind;
    string s;
    send_idle_pct = idle;
    stall_pct = stall;
    items = 0;
    while (items < n_items) begin
      kind = $urandom_range(99);
      if (kind < 70) s = rand_prefix($urandom_range(0, 8));
      else if (kind < 78) s = rand_prefix($urandom_range(20, 31));
      else if (kind < 86) s = corrupt(rand_prefix($urandom_range(1, 6)));
      else if (kind < 92) s = rand_noise($urandom_range(1, 10));
      else if (kind < 96) s = rand_noise($urandom_range(60, 70));
      else begin
        // nul byte and a high code, counted as non-digits: bad count
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b0);
        s = "*";
        items += 2;
      end
      send_string(s);
      items += s.len();
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_req = '0;
    out_stall = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed cases: operators, errors and edge values.
    send_string("5");
    send_string("+34");
    send_string("-34");
    send_string("*99");
    send_string("/93");
    send_string("^23");
    send_string("/90");                    // divide by zero
    send_string("^0-01");                  // zero to a negative power
    send_string("^1-02");                  // base one, negative exponent
    send_string("^/0-1-03");               // bad count: four digits, four operators
    send_string("^/0-1-02");               // bad count: four digits, four operators
    send_string("^4-01");                  // other base truncates to zero
    send_string("^00");                    // zero to the zero
    send_string("/^29-01*-01^29-01");      // bad count: ten digits, seven operators
    send_string("^99");                    // nine to the ninth, fits in 32 bits
    send_string("+3");                     // bad count
    send_string("+a34");                   // letter counts against the balance: bad count
    send_string("+}}1");                   // non-digits count against the balance: bad count
    send_string("33+");                    // underflow at the operator
    send_string({"+", rand_noise(0), "1", "2"});
    send_string(rand_noise(65));           // too long
    send_string({rand_prefix(31), "0"});   // 64 chars, bad count
    send_string(rand_prefix(31));          // 63 chars, legal
    // Full buffer, 64 chars: three operands for one +, so bad count.
    send_string({"+", rand_prefix(30), "12"});

    run_phase(330, 0, 0);
    run_phase(330, 45, 0);
    run_phase(330, 0, 45);
    run_phase(330, 20, 20);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit: well above the slowest correct run.
  initial begin
    #60ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
